// ----- rtl/mhpq_pkg.sv -----
`timescale 1ns / 1ps

package mhpq_pkg;

   localparam int KEY_W    = 32;
   localparam int SLOT_W   = 6;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   typedef logic [REQ_W-1:0]    req_type_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [KEY_W-1:0]    key_type;

   localparam req_type_type REQ_INSERT   = 2'd0;
   localparam req_type_type REQ_EXTRACT  = 2'd1;
   localparam req_type_type REQ_DECREASE = 2'd2;

   localparam status_type ST_OK            = 3'd0;
   localparam status_type ST_EMPTY         = 3'd1;
   localparam status_type ST_FULL          = 3'd2;
   localparam status_type ST_NOT_DECREASED = 3'd3;
   localparam status_type ST_BAD_SLOT      = 3'd4;

endpackage

// ----- rtl/mhpq_ram.sv -----
`timescale 1ns / 1ps

module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/min_heap_priority_queue.sv -----
`timescale 1ns / 1ps

// Binary min-heap priority queue of signed 32-bit keys held in one RAM with a single
// write port and a single registered read port. Each request (insert, extract minimum,
// decrease key at a slot) returns one response with a status, the extracted or current
// minimum, a flag for that key and the entry count. Requests are served one at a time.
// Insert and decrease walk the heap upward one level at a time; extract reads one or
// two children per level walked downward through the single RAM read port. A finished
// response sits in an output register, and the next request is taken once that
// response has been loaded there. The key store needs no clearing after reset.
module min_heap_priority_queue #(
   parameter int CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mhpq_pkg::REQ_W-1:0]          req_req_type,
   input  logic signed [mhpq_pkg::KEY_W-1:0]   req_key,
   input  logic [mhpq_pkg::SLOT_W-1:0]         req_slot,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mhpq_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [mhpq_pkg::KEY_W-1:0]   rsp_result_key,
   output logic                                rsp_min_valid,
   output logic [mhpq_pkg::COUNT_W-1:0]        rsp_entry_count
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = AW + 2;
   localparam int SW = (CW > mhpq_pkg::SLOT_W) ? CW : mhpq_pkg::SLOT_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_UP   = 3'd1;
   localparam logic [2:0] S_DEC  = 3'd2;
   localparam logic [2:0] S_LAST = 3'd3;
   localparam logic [2:0] S_DN_L = 3'd4;
   localparam logic [2:0] S_DN_R = 3'd5;
   localparam logic [2:0] S_PUT  = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   logic [2:0]                  state_ff, state_in;
   logic [AW-1:0]               pos_ff, pos_in;
   mhpq_pkg::key_type           key_ff, key_in;
   mhpq_pkg::key_type           lkey_ff, lkey_in;
   mhpq_pkg::key_type           xkey_ff, xkey_in;
   mhpq_pkg::key_type           root_ff;
   logic [CW-1:0]               count_ff, count_in;
   mhpq_pkg::status_type        status_ff, status_in;
   logic                        extracted_ff, extracted_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   mhpq_pkg::status_type        rsp_status_ff, rsp_status_in;
   mhpq_pkg::key_type           rsp_key_ff, rsp_key_in;
   logic                        rsp_min_valid_ff, rsp_min_valid_in;
   logic [mhpq_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                        wr_en, rd_en;
   logic [AW-1:0]               wr_addr, rd_addr;
   mhpq_pkg::key_type           wr_data, rd_data;

   logic                        accept;
   logic [AW-1:0]               cnt_pos, up_idx, up2_idx;
   logic [XW-1:0]               l_idx, r_idx, n_x, s_idx, sl_idx;
   mhpq_pkg::key_type           c_key;

   mhpq_ram #(
      .WIDTH (mhpq_pkg::KEY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   assign cnt_pos = AW'(count_ff);
   assign up_idx  = (pos_ff - AW'(1)) >> 1;
   assign up2_idx = (up_idx - AW'(1)) >> 1;
   assign l_idx   = (XW'(pos_ff) << 1) + XW'(1);
   assign r_idx   = l_idx + XW'(1);
   assign n_x     = XW'(count_ff);

   // smaller child: right only when strictly smaller than left
   always_comb begin
      if (state_ff == S_DN_R && $signed(rd_data) < $signed(lkey_ff)) begin
         s_idx = r_idx;
         c_key = rd_data;
      end else if (state_ff == S_DN_R) begin
         s_idx = l_idx;
         c_key = lkey_ff;
      end else begin
         s_idx = l_idx;
         c_key = rd_data;
      end
   end
   assign sl_idx = (s_idx << 1) + XW'(1);

   always_comb begin
      state_in         = state_ff;
      pos_in           = pos_ff;
      key_in           = key_ff;
      lkey_in          = lkey_ff;
      xkey_in          = xkey_ff;
      count_in         = count_ff;
      status_in        = status_ff;
      extracted_in     = extracted_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_key_in       = rsp_key_ff;
      rsp_min_valid_in = rsp_min_valid_ff;
      rsp_count_in     = rsp_count_ff;
      wr_en            = 1'b0;
      wr_addr          = pos_ff;
      wr_data          = key_ff;
      rd_en            = 1'b0;
      rd_addr          = up_idx;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in    = mhpq_pkg::ST_OK;
               extracted_in = 1'b0;
               key_in       = req_key;
               state_in     = S_DONE;
               case (req_req_type)
                  mhpq_pkg::REQ_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in = mhpq_pkg::ST_FULL;
                     end else begin
                        count_in = count_ff + CW'(1);
                        pos_in   = cnt_pos;
                        if (count_ff == '0) begin
                           wr_en   = 1'b1;
                           wr_addr = '0;
                           wr_data = req_key;
                        end else begin
                           rd_en    = 1'b1;
                           rd_addr  = (cnt_pos - AW'(1)) >> 1;
                           state_in = S_UP;
                        end
                     end
                  end
                  mhpq_pkg::REQ_EXTRACT: begin
                     if (count_ff == '0) begin
                        status_in = mhpq_pkg::ST_EMPTY;
                     end else begin
                        xkey_in      = root_ff;
                        extracted_in = 1'b1;
                        count_in     = count_ff - CW'(1);
                        if (count_ff != CW'(1)) begin
                           rd_en    = 1'b1;
                           rd_addr  = AW'(count_ff - CW'(1));
                           state_in = S_LAST;
                        end
                     end
                  end
                  mhpq_pkg::REQ_DECREASE: begin
                     if (SW'(req_slot) >= SW'(count_ff)) begin
                        status_in = mhpq_pkg::ST_BAD_SLOT;
                     end else begin
                        pos_in   = AW'(req_slot);
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req_slot);
                        state_in = S_DEC;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_UP: begin
            if ($signed(key_ff) < $signed(rd_data)) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               pos_in  = up_idx;
               if (up_idx == '0) begin
                  state_in = S_PUT;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = up2_idx;
                  state_in = S_UP;
               end
            end else begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DEC: begin
            if ($signed(rd_data) < $signed(key_ff)) begin
               status_in = mhpq_pkg::ST_NOT_DECREASED;
               state_in  = S_DONE;
            end else if (pos_ff == '0) begin
               state_in = S_PUT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = up_idx;
               state_in = S_UP;
            end
         end
         S_LAST: begin
            key_in = rd_data;
            pos_in = '0;
            if (XW'(1) < n_x) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(1);
               state_in = S_DN_L;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = rd_data;
               state_in = S_DONE;
            end
         end
         S_DN_L, S_DN_R: begin
            lkey_in = rd_data;
            if (state_ff == S_DN_L && r_idx < n_x) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(r_idx);
               state_in = S_DN_R;
            end else if ($signed(c_key) < $signed(key_ff)) begin
               wr_en   = 1'b1;
               wr_data = c_key;
               pos_in  = AW'(s_idx);
               if (sl_idx < n_x) begin
                  rd_en    = 1'b1;
                  rd_addr  = AW'(sl_idx);
                  state_in = S_DN_L;
               end else begin
                  state_in = S_PUT;
               end
            end else begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end
         end
         S_PUT: begin
            wr_en    = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = status_ff;
               rsp_count_in     = mhpq_pkg::COUNT_W'(count_ff);
               rsp_min_valid_in = extracted_ff || (count_ff != '0);
               if (extracted_ff) begin
                  rsp_key_in = xkey_ff;
               end else if (count_ff != '0) begin
                  rsp_key_in = root_ff;
               end else begin
                  rsp_key_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff           <= pos_in;
      key_ff           <= key_in;
      lkey_ff          <= lkey_in;
      xkey_ff          <= xkey_in;
      status_ff        <= status_in;
      extracted_ff     <= extracted_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_key_ff       <= rsp_key_in;
      rsp_min_valid_ff <= rsp_min_valid_in;
      rsp_count_ff     <= rsp_count_in;
      // shadow copy of the root entry
      if (wr_en && wr_addr == '0) begin
         root_ff <= wr_data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_key  = $signed(rsp_key_ff);
   assign rsp_min_valid   = rsp_min_valid_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// ----- rtl/mhpq_checker.sv -----
`timescale 1ns / 1ps

module mhpq_checker #(
   parameter int CAPACITY = 64
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [mhpq_pkg::STATUS_W-1:0]       rsp_status,
   input logic signed [mhpq_pkg::KEY_W-1:0]   rsp_result_key,
   input logic                                rsp_min_valid,
   input logic [mhpq_pkg::COUNT_W-1:0]        rsp_entry_count
);

   // stalled transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_result_key) && $stable(rsp_min_valid) && $stable(rsp_entry_count))
      else $error("response changed while stalled");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mhpq_pkg::ST_EMPTY |-> !rsp_min_valid && rsp_entry_count == '0)
      else $error("empty status with entries");

   a_no_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_min_valid |-> rsp_result_key == '0)
      else $error("key shown without a minimum");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mhpq_pkg::ST_FULL
         |-> rsp_entry_count == mhpq_pkg::COUNT_W'(CAPACITY) && rsp_min_valid)
      else $error("full status with wrong count");

   a_count_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_count != '0 |-> rsp_min_valid)
      else $error("entries present without a minimum");

endmodule

bind min_heap_priority_queue mhpq_checker #(.CAPACITY(CAPACITY)) u_mhpq_checker (.*);
